// ----- rtl/cpa_pkg.sv -----
package cpa_pkg;

    // Field widths
    localparam int FUNC_ID_W = 10;
    localparam int LEVEL_W   = 8;
    localparam int TIME_W    = 63;
    localparam int MEM_W     = 48;
    localparam int ACC_W     = 64;
    localparam int CALLS_W   = 32;
    localparam int SEEN_W    = 11;
    localparam int DEPTH_W   = 6;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CFG_SEL_BIT = 2;
    localparam logic REG_EXCLUSIVE = 1'b0;
    localparam logic REG_DEEPEST   = 1'b1;
    localparam logic [DEPTH_W-1:0] DEEPEST_RESET = 6'd62;

    // Shift of the reciprocal used to reduce func_id modulo the table depth
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam int PROD_W      = 30;

    typedef struct packed {
        logic [FUNC_ID_W-1:0] func_id;
        logic [LEVEL_W-1:0]   call_level;
        logic [TIME_W-1:0]    entry_wall;
        logic [TIME_W-1:0]    exit_wall;
        logic [TIME_W-1:0]    entry_cpu;
        logic [TIME_W-1:0]    exit_cpu;
        logic [MEM_W-1:0]     entry_mem;
        logic [MEM_W-1:0]     exit_mem;
        logic [MEM_W-1:0]     entry_peak;
        logic [MEM_W-1:0]     exit_peak;
    } cpa_in_t;

    typedef struct packed {
        logic [CALLS_W-1:0]      total_calls;
        logic signed [ACC_W-1:0] total_wall;
        logic signed [ACC_W-1:0] total_cpu;
        logic signed [ACC_W-1:0] net_memory;
        logic signed [ACC_W-1:0] largest_peak;
        logic [SEEN_W-1:0]       distinct_funcs;
        logic                    level_too_deep;
    } cpa_out_t;

    typedef struct packed {
        logic               exclusive_mode;
        logic [DEPTH_W-1:0] deepest_level;
    } cpa_cfg_t;

    // One row of the per-function statistics table
    typedef struct packed {
        logic               valid;
        logic [CALLS_W-1:0] calls;
        logic [ACC_W-1:0]   wall;
        logic [ACC_W-1:0]   cpu;
        logic [ACC_W-1:0]   mem;
        logic [ACC_W-1:0]   peak;
    } func_row_t;

    // One row of the per-level child time accumulators
    typedef struct packed {
        logic [ACC_W-1:0] wall;
        logic [ACC_W-1:0] cpu;
    } level_row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_CHARGE,
        ST_UPDATE
    } cpa_state_t;

endpackage

// ----- rtl/cpa_func_table.sv -----
module cpa_func_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output cpa_pkg::func_row_t  rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  cpa_pkg::func_row_t  wr_data
);
    import cpa_pkg::*;

    func_row_t rows_reg [DEPTH];
    func_row_t rd_data_reg;

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rows_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rows_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/cpa_level_table.sv -----
module cpa_level_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output cpa_pkg::level_row_t rd_data_a,
    output cpa_pkg::level_row_t rd_data_b,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  cpa_pkg::level_row_t wr_data
);
    import cpa_pkg::*;

    level_row_t rows_reg [DEPTH];
    level_row_t rd_a_reg;
    level_row_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rows_reg[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports: the call's level and the level below it
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= rows_reg[rd_addr_a];
            rd_b_reg <= rows_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- rtl/cpa_engine.sv -----
module cpa_engine #(
    parameter int FUNC_ENTRIES = 1024,
    parameter int LEVEL_SLOTS  = 64,
    parameter int FW           = 10,
    parameter int LW           = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cpa_pkg::cpa_cfg_t   cfg,
    // Input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  cpa_pkg::cpa_in_t    s_payload,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output cpa_pkg::cpa_out_t   m_payload,
    // Function table
    output logic                ft_rd_en,
    output logic [FW-1:0]       ft_rd_addr,
    input  cpa_pkg::func_row_t  ft_rd_data,
    output logic                ft_wr_en,
    output logic [FW-1:0]       ft_wr_addr,
    output cpa_pkg::func_row_t  ft_wr_data,
    // Level table
    output logic                lt_rd_en,
    output logic [LW-1:0]       lt_rd_addr_a,
    output logic [LW-1:0]       lt_rd_addr_b,
    input  cpa_pkg::level_row_t lt_rd_data_a,
    input  cpa_pkg::level_row_t lt_rd_data_b,
    output logic                lt_wr_en,
    output logic [LW-1:0]       lt_wr_addr,
    output cpa_pkg::level_row_t lt_wr_data
);
    import cpa_pkg::*;

    localparam int CLEAR_LEN = (FUNC_ENTRIES > LEVEL_SLOTS) ? FUNC_ENTRIES : LEVEL_SLOTS;
    localparam int CW        = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
    localparam int RECIP     = (2**RECIP_SHIFT + FUNC_ENTRIES - 1) / FUNC_ENTRIES;
    localparam int ADDR_X_W  = 17;

    cpa_state_t state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;

    cpa_in_t              item_reg;
    logic [FUNC_ID_W-1:0] quot_reg;
    logic [ACC_W-1:0]     dwall_reg, dcpu_reg, dmem_reg, dpeak_reg;
    logic                 time_en_reg;   // times are added to the totals
    logic                 charge_reg;    // exclusive charging through the level table
    logic                 flag_reg;
    logic                 has_below_reg;
    logic [FW-1:0]        idx_reg;
    logic [LW-1:0]        lvl_addr_reg;

    logic [ACC_W-1:0]     wall_share_reg, cpu_share_reg;
    level_row_t           lvl_new_reg;
    logic [ACC_W-1:0]     mem_tot_reg, peak_max_reg;
    logic [CALLS_W-1:0]   calls_reg;
    logic                 new_func_reg;

    logic [SEEN_W-1:0]    seen_reg, seen_next;
    cpa_out_t             out_reg;
    logic                 out_valid_reg, out_valid_next;

    logic                 accept;
    logic                 out_free;
    logic                 finish;
    logic [PROD_W-1:0]    quot_prod;
    logic [26:0]          back_prod;
    logic [FUNC_ID_W-1:0] rem10;
    logic [ADDR_X_W-1:0]  rem_x;
    logic [15:0]          lvl_x;
    logic [15:0]          lvl_up_x;
    logic                 lvl_ok;
    logic [ACC_W-1:0]     below_wall, below_cpu;
    func_row_t            row_upd;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign finish   = (state_reg == ST_UPDATE) && out_free;

    // Index reduction: quotient by reciprocal, remainder by back-multiply
    assign quot_prod = PROD_W'(item_reg.func_id) * PROD_W'(RECIP);
    assign back_prod = 27'(quot_reg) * 27'(FUNC_ENTRIES);
    assign rem10     = item_reg.func_id - back_prod[FUNC_ID_W-1:0];
    assign rem_x     = ADDR_X_W'(rem10);

    assign lvl_x    = 16'(item_reg.call_level);
    assign lvl_up_x = lvl_x + 16'd1;
    assign lvl_ok   = (item_reg.call_level <= LEVEL_W'(cfg.deepest_level))
                   && (lvl_x < 16'(LEVEL_SLOTS));

    // Child time accumulated one level below; none beyond the last slot
    assign below_wall = has_below_reg ? lt_rd_data_b.wall : '0;
    assign below_cpu  = has_below_reg ? lt_rd_data_b.cpu  : '0;

    // Updated row written back at the end of an item
    always_comb begin
        row_upd       = ft_rd_data;
        row_upd.valid = 1'b1;
        row_upd.calls = calls_reg;
        row_upd.wall  = ft_rd_data.wall + (time_en_reg ? wall_share_reg : '0);
        row_upd.cpu   = ft_rd_data.cpu  + (time_en_reg ? cpu_share_reg  : '0);
        row_upd.mem   = mem_tot_reg;
        row_upd.peak  = peak_max_reg;
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state, memory ports and handshake
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;

        ft_rd_en     = 1'b0;
        ft_rd_addr   = rem_x[FW-1:0];
        ft_wr_en     = 1'b0;
        ft_wr_addr   = idx_reg;
        ft_wr_data   = row_upd;
        lt_rd_en     = 1'b0;
        lt_rd_addr_a = lvl_x[LW-1:0];
        lt_rd_addr_b = lvl_up_x[LW-1:0];
        lt_wr_en     = 1'b0;
        lt_wr_addr   = lvl_addr_reg;
        lt_wr_data   = lvl_new_reg;

        case (state_reg)
            ST_CLEAR: begin
                ft_wr_en   = ({1'b0, clr_cnt_reg} < (CW+1)'(FUNC_ENTRIES));
                ft_wr_addr = clr_cnt_reg[FW-1:0];
                ft_wr_data = '0;
                lt_wr_en   = ({1'b0, clr_cnt_reg} < (CW+1)'(LEVEL_SLOTS));
                lt_wr_addr = clr_cnt_reg[LW-1:0];
                lt_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CLEAR_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                ft_rd_en   = 1'b1;
                lt_rd_en   = 1'b1;
                state_next = ST_CHARGE;
            end
            ST_CHARGE: begin
                // Caller takes over the level below: clear it
                lt_wr_en   = charge_reg && has_below_reg;
                lt_wr_addr = lvl_up_x[LW-1:0];
                lt_wr_data = '0;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    ft_wr_en       = 1'b1;
                    lt_wr_en       = charge_reg;
                    seen_next      = seen_reg + SEEN_W'(new_func_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_payload;
        end
    end

    // Index stage: quotient, differences and mode decisions
    always_ff @(posedge aclk) begin
        if (state_reg == ST_INDEX) begin
            quot_reg      <= quot_prod[PROD_W-1 -: FUNC_ID_W];
            dwall_reg     <= ACC_W'(item_reg.exit_wall) - ACC_W'(item_reg.entry_wall);
            dcpu_reg      <= ACC_W'(item_reg.exit_cpu)  - ACC_W'(item_reg.entry_cpu);
            dmem_reg      <= ACC_W'(item_reg.exit_mem)  - ACC_W'(item_reg.entry_mem);
            dpeak_reg     <= ACC_W'(item_reg.exit_peak) - ACC_W'(item_reg.entry_peak);
            time_en_reg   <= !cfg.exclusive_mode || lvl_ok;
            charge_reg    <= cfg.exclusive_mode && lvl_ok;
            flag_reg      <= cfg.exclusive_mode && !lvl_ok;
            has_below_reg <= (lvl_up_x < 16'(LEVEL_SLOTS));
            lvl_addr_reg  <= lvl_x[LW-1:0];
        end
    end

    // Read stage: remember the reduced index for write-back
    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            idx_reg <= rem_x[FW-1:0];
        end
    end

    // Charge stage: level accumulators, caller share and the plain fields
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHARGE) begin
            lvl_new_reg.wall <= lt_rd_data_a.wall + dwall_reg;
            lvl_new_reg.cpu  <= lt_rd_data_a.cpu  + dcpu_reg;
            wall_share_reg   <= charge_reg ? (dwall_reg - below_wall) : dwall_reg;
            cpu_share_reg    <= charge_reg ? (dcpu_reg  - below_cpu)  : dcpu_reg;
            mem_tot_reg      <= ft_rd_data.mem + dmem_reg;
            peak_max_reg     <= ($signed(dpeak_reg) > $signed(ft_rd_data.peak))
                                ? dpeak_reg : ft_rd_data.peak;
            calls_reg        <= ft_rd_data.calls + CALLS_W'(1);
            new_func_reg     <= !ft_rd_data.valid;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (finish) begin
            out_reg.total_calls    <= row_upd.calls;
            out_reg.total_wall     <= row_upd.wall;
            out_reg.total_cpu      <= row_upd.cpu;
            out_reg.net_memory     <= row_upd.mem;
            out_reg.largest_peak   <= row_upd.peak;
            out_reg.distinct_funcs <= seen_next;
            out_reg.level_too_deep <= flag_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ----- rtl/call_profile_accumulator.sv -----
// Each item runs capture, index reduction, table read, level charge and write-back through
// the two tables in sequence; the result is registered once the result register is free.
// A new item is accepted only in the idle state, after the last one has been written back.
// Reset: aresetn is synchronous, active low; afterwards a clearing pass over every address
// of both tables zeroes them before s_ready rises.
module call_profile_accumulator #(
    parameter int FUNC_ENTRIES = 1024,
    parameter int LEVEL_SLOTS  = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cpa_pkg::PADDR_W-1:0]        paddr,
    input  logic [cpa_pkg::PDATA_W-1:0]        pwdata,
    output logic [cpa_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cpa_pkg::cpa_in_t                   s_payload,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output cpa_pkg::cpa_out_t                  m_payload
);
    import cpa_pkg::*;

    localparam int FW = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1;
    localparam int LW = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;

    cpa_cfg_t   cfg_reg;
    logic       cfg_wr;

    logic       ft_rd_en, ft_wr_en;
    logic [FW-1:0] ft_rd_addr, ft_wr_addr;
    func_row_t  ft_rd_data, ft_wr_data;

    logic       lt_rd_en, lt_wr_en;
    logic [LW-1:0] lt_rd_addr_a, lt_rd_addr_b, lt_wr_addr;
    level_row_t lt_rd_data_a, lt_rd_data_b, lt_wr_data;

    // Register writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.exclusive_mode <= 1'b0;
            cfg_reg.deepest_level  <= DEEPEST_RESET;
        end else if (cfg_wr) begin
            case (paddr[CFG_SEL_BIT])
                REG_EXCLUSIVE: cfg_reg.exclusive_mode <= pwdata[0];
                REG_DEEPEST:   cfg_reg.deepest_level  <= pwdata[DEPTH_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[CFG_SEL_BIT])
            REG_EXCLUSIVE: prdata = PDATA_W'(cfg_reg.exclusive_mode);
            REG_DEEPEST:   prdata = PDATA_W'(cfg_reg.deepest_level);
            default:       prdata = '0;
        endcase
    end

    cpa_engine #(
        .FUNC_ENTRIES (FUNC_ENTRIES),
        .LEVEL_SLOTS  (LEVEL_SLOTS),
        .FW           (FW),
        .LW           (LW)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .ft_rd_en     (ft_rd_en),
        .ft_rd_addr   (ft_rd_addr),
        .ft_rd_data   (ft_rd_data),
        .ft_wr_en     (ft_wr_en),
        .ft_wr_addr   (ft_wr_addr),
        .ft_wr_data   (ft_wr_data),
        .lt_rd_en     (lt_rd_en),
        .lt_rd_addr_a (lt_rd_addr_a),
        .lt_rd_addr_b (lt_rd_addr_b),
        .lt_rd_data_a (lt_rd_data_a),
        .lt_rd_data_b (lt_rd_data_b),
        .lt_wr_en     (lt_wr_en),
        .lt_wr_addr   (lt_wr_addr),
        .lt_wr_data   (lt_wr_data)
    );

    cpa_func_table #(
        .DEPTH (FUNC_ENTRIES),
        .AW    (FW)
    ) u_func_table (
        .aclk    (aclk),
        .rd_en   (ft_rd_en),
        .rd_addr (ft_rd_addr),
        .rd_data (ft_rd_data),
        .wr_en   (ft_wr_en),
        .wr_addr (ft_wr_addr),
        .wr_data (ft_wr_data)
    );

    cpa_level_table #(
        .DEPTH (LEVEL_SLOTS),
        .AW    (LW)
    ) u_level_table (
        .aclk      (aclk),
        .rd_en     (lt_rd_en),
        .rd_addr_a (lt_rd_addr_a),
        .rd_addr_b (lt_rd_addr_b),
        .rd_data_a (lt_rd_data_a),
        .rd_data_b (lt_rd_data_b),
        .wr_en     (lt_wr_en),
        .wr_addr   (lt_wr_addr),
        .wr_data   (lt_wr_data)
    );

endmodule

// ----- sim/call_profile_accumulator_test.sv -----
module call_profile_accumulator_test;
    import cpa_pkg::*;

    localparam int FUNC_ENTRIES = 1024;
    localparam int LEVEL_SLOTS  = 64;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int LONG_HOLD = 300;

    localparam logic [PADDR_W-1:0] ADDR_EXCLUSIVE = {REG_EXCLUSIVE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_DEEPEST   = {REG_DEEPEST, 2'b00};

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [MEM_W-1:0]  MEM_MAX  = {MEM_W{1'b1}};

    // Clock, reset and block inputs, all known from time zero
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    cpa_in_t             s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    cpa_out_t            m_payload;

    // Stimulus and expected-result stores
    cpa_in_t     pending_records[$];
    cpa_out_t    expected_totals[$];
    int unsigned records_outstanding = 0;
    int unsigned records_queued = 0;
    int unsigned mismatch_count = 0;

    // Idle control
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;
    bit          receiver_held = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          offering = 1'b0;
    bit          send_done = 1'b0;
    cpa_in_t     next_record = '0;

    // Predictor copy of configuration and statistics tables
    bit                mode_exclusive = 1'b0;
    bit [DEPTH_W-1:0]  level_limit = DEEPEST_RESET;
    bit                fn_seen  [FUNC_ENTRIES];
    bit [CALLS_W-1:0]  fn_calls [FUNC_ENTRIES];
    bit [ACC_W-1:0]    fn_wall  [FUNC_ENTRIES];
    bit [ACC_W-1:0]    fn_cpu   [FUNC_ENTRIES];
    bit [ACC_W-1:0]    fn_mem   [FUNC_ENTRIES];
    bit [ACC_W-1:0]    fn_peak  [FUNC_ENTRIES];
    bit [ACC_W-1:0]    child_wall [LEVEL_SLOTS];
    bit [ACC_W-1:0]    child_cpu  [LEVEL_SLOTS];
    bit [SEEN_W-1:0]   distinct_total = '0;

    call_profile_accumulator #(
        .FUNC_ENTRIES(FUNC_ENTRIES),
        .LEVEL_SLOTS (LEVEL_SLOTS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    // Updates the statistics tables for one call record and returns the new totals
    function automatic cpa_out_t predict_totals(input cpa_in_t rec);
        int unsigned fn;
        int unsigned lvl;
        bit [ACC_W-1:0] d_wall;
        bit [ACC_W-1:0] d_cpu;
        bit [ACC_W-1:0] d_mem;
        bit [ACC_W-1:0] d_peak;
        bit [ACC_W-1:0] below_wall;
        bit [ACC_W-1:0] below_cpu;
        cpa_out_t res;
        fn = rec.func_id % FUNC_ENTRIES;
        lvl = rec.call_level;
        d_wall = {1'b0, rec.exit_wall} - {1'b0, rec.entry_wall};
        d_cpu  = {1'b0, rec.exit_cpu} - {1'b0, rec.entry_cpu};
        d_mem  = {16'd0, rec.exit_mem} - {16'd0, rec.entry_mem};
        d_peak = {16'd0, rec.exit_peak} - {16'd0, rec.entry_peak};
        res = '0;

        if (!fn_seen[fn]) begin
            fn_seen[fn] = 1'b1;
            distinct_total++;
        end

        // Exclusive time: charge this level, take back what the callees one level down used
        if (mode_exclusive) begin
            if (lvl <= level_limit && lvl < LEVEL_SLOTS) begin
                child_wall[lvl] += d_wall;
                child_cpu[lvl] += d_cpu;
                below_wall = '0;
                below_cpu = '0;
                if (lvl + 1 < LEVEL_SLOTS) begin
                    below_wall = child_wall[lvl + 1];
                    below_cpu = child_cpu[lvl + 1];
                    child_wall[lvl + 1] = '0;
                    child_cpu[lvl + 1] = '0;
                end
                fn_wall[fn] += d_wall - below_wall;
                fn_cpu[fn] += d_cpu - below_cpu;
            end else begin
                res.level_too_deep = 1'b1;
            end
        end else begin
            fn_wall[fn] += d_wall;
            fn_cpu[fn] += d_cpu;
        end

        fn_mem[fn] += d_mem;
        if ($signed(d_peak) > $signed(fn_peak[fn])) begin
            fn_peak[fn] = d_peak;
        end
        fn_calls[fn]++;

        res.total_calls    = fn_calls[fn];
        res.total_wall     = fn_wall[fn];
        res.total_cpu      = fn_cpu[fn];
        res.net_memory     = fn_mem[fn];
        res.largest_peak   = fn_peak[fn];
        res.distinct_funcs = distinct_total;
        return res;
    endfunction

    task automatic check_result(input cpa_out_t got);
        cpa_out_t want;
        if (expected_totals.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %h", got));
            return;
        end
        want = expected_totals.pop_front();
        records_outstanding--;
        if (got.total_calls !== want.total_calls)
            report_mismatch($sformatf("total_calls %h, expected %h",
                got.total_calls, want.total_calls));
        if (got.total_wall !== want.total_wall)
            report_mismatch($sformatf("total_wall %h, expected %h",
                got.total_wall, want.total_wall));
        if (got.total_cpu !== want.total_cpu)
            report_mismatch($sformatf("total_cpu %h, expected %h",
                got.total_cpu, want.total_cpu));
        if (got.net_memory !== want.net_memory)
            report_mismatch($sformatf("net_memory %h, expected %h",
                got.net_memory, want.net_memory));
        if (got.largest_peak !== want.largest_peak)
            report_mismatch($sformatf("largest_peak %h, expected %h",
                got.largest_peak, want.largest_peak));
        if (got.distinct_funcs !== want.distinct_funcs)
            report_mismatch($sformatf("distinct_funcs %0d, expected %0d",
                got.distinct_funcs, want.distinct_funcs));
        if (got.level_too_deep !== want.level_too_deep)
            report_mismatch($sformatf("level_too_deep %b, expected %b",
                got.level_too_deep, want.level_too_deep));
    endtask

    // Input side: predict on each transfer, then offer the next record at the falling edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_totals.push_back(predict_totals(s_payload));
            send_done = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (send_done) begin
            send_done = 1'b0;
            offering = 1'b0;
        end
        if (aresetn && !offering) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_records.size() != 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 8);
                end else begin
                    next_record = pending_records.pop_front();
                    offering = 1'b1;
                end
            end
        end
        s_valid <= offering;
        s_payload <= next_record;
    end

    // Result side: check each transfer, stall in short random bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_payload);
        end
    end

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_held;
        end
    end

    // One long hold-off on the result side so the block backs up into its input
    initial begin
        wait (hold_request);
        @(posedge aclk);
        receiver_held = 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        receiver_held = 1'b0;
    end

    task automatic queue_record(
        input logic [FUNC_ID_W-1:0] fid,
        input logic [LEVEL_W-1:0]   lvl,
        input logic [TIME_W-1:0]    ewall,
        input logic [TIME_W-1:0]    xwall,
        input logic [TIME_W-1:0]    ecpu,
        input logic [TIME_W-1:0]    xcpu,
        input logic [MEM_W-1:0]     emem,
        input logic [MEM_W-1:0]     xmem,
        input logic [MEM_W-1:0]     epeak,
        input logic [MEM_W-1:0]     xpeak
    );
        cpa_in_t rec;
        rec.func_id    = fid;
        rec.call_level = lvl;
        rec.entry_wall = ewall;
        rec.exit_wall  = xwall;
        rec.entry_cpu  = ecpu;
        rec.exit_cpu   = xcpu;
        rec.entry_mem  = emem;
        rec.exit_mem   = xmem;
        rec.entry_peak = epeak;
        rec.exit_peak  = xpeak;
        pending_records.push_back(rec);
        records_outstanding++;
        records_queued++;
    endtask

    task automatic queue_noise_record();
        queue_record(10'($urandom), 8'($urandom),
            63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
            63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
            48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
            48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    endtask

    // Random call tree: records come out in return order, callees before callers
    task automatic queue_call_tree(
        input int unsigned depth_cap,
        input int unsigned push_pct,
        input int unsigned step_limit
    );
        bit [TIME_W-1:0]    now_wall;
        bit [TIME_W-1:0]    now_cpu;
        bit [MEM_W-1:0]     now_mem;
        bit [MEM_W-1:0]     now_peak;
        bit [TIME_W-1:0]    open_wall [80];
        bit [TIME_W-1:0]    open_cpu  [80];
        bit [MEM_W-1:0]     open_mem  [80];
        bit [MEM_W-1:0]     open_peak [80];
        bit [FUNC_ID_W-1:0] open_fn   [80];
        int unsigned depth;
        int unsigned steps;
        int unsigned wall_step;
        now_wall = 63'({$urandom, $urandom});
        now_cpu  = 63'({$urandom, $urandom});
        now_mem  = 48'({$urandom, $urandom});
        now_peak = now_mem + 48'($urandom_range(0, 65535));
        depth = 0;
        steps = 0;
        do begin
            wall_step = $urandom_range(0, 5000);
            now_wall += 63'(wall_step);
            now_cpu += 63'($urandom_range(0, wall_step));
            now_mem = now_mem + 48'($urandom_range(0, 4096)) - 48'($urandom_range(0, 4096));
            if (now_mem > now_peak) begin
                now_peak = now_mem;
            end
            if (depth < depth_cap &&
                (depth == 0 || (steps < step_limit && $urandom_range(0, 99) < push_pct))) begin
                // mostly a few hot functions so entries accumulate
                if ($urandom_range(0, 9) < 7) begin
                    open_fn[depth] = $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                          : 10'(1023 - $urandom_range(0, 7));
                end else begin
                    open_fn[depth] = 10'($urandom);
                end
                open_wall[depth] = now_wall;
                open_cpu[depth]  = now_cpu;
                open_mem[depth]  = now_mem;
                open_peak[depth] = now_peak;
                depth++;
            end else begin
                depth--;
                queue_record(open_fn[depth], 8'(depth), open_wall[depth], now_wall,
                    open_cpu[depth], now_cpu, open_mem[depth], now_mem,
                    open_peak[depth], now_peak);
            end
            steps++;
        end while (depth > 0);
    endtask

    task automatic queue_random_records(input int unsigned count);
        int unsigned start;
        start = records_queued;
        while (records_queued - start < count) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_call_tree(70, 90, 120);
                end else begin
                    queue_call_tree($urandom_range(2, 8), 50, 40);
                end
            end else begin
                repeat ($urandom_range(1, 3)) queue_noise_record();
            end
        end
    endtask

    // APB write, then read the register back
    task automatic write_register(
        input logic [PADDR_W-1:0] addr,
        input logic [PDATA_W-1:0] value,
        input logic [PDATA_W-1:0] mask
    );
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== (value & mask)) begin
            report_mismatch($sformatf("register %0d reads %h, wrote %h", addr, prdata, value));
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input bit excl, input bit [DEPTH_W-1:0] limit);
        write_register(ADDR_EXCLUSIVE, PDATA_W'(excl), 32'h1);
        write_register(ADDR_DEEPEST, PDATA_W'(limit), 32'h3f);
        mode_exclusive = excl;
        level_limit = limit;
    endtask

    // Block is idle once every queued record has produced its result
    task automatic wait_idle();
        while (records_outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    initial begin : stimulus
        int unsigned guard;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Inclusive mode at reset settings: extremes and readings that went backwards
        queue_record(10'd0, 8'd0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_record(10'd1023, 8'd255, '0, TIME_MAX, '0, TIME_MAX, '0, MEM_MAX, '0, MEM_MAX);
        queue_record(10'd1023, 8'd128, TIME_MAX, '0, TIME_MAX, '0, MEM_MAX, '0, MEM_MAX, '0);
        queue_record(10'd512, 8'd1, 63'd100, 63'd250, 63'd50, 63'd90,
            48'd1000, 48'd900, 48'd2000, 48'd1500);
        queue_record(10'd512, 8'd1, 63'd300, 63'd320, 63'd95, 63'd99,
            48'd900, 48'd1200, 48'd1000, 48'd1700);
        wait_idle();

        // Exclusive mode: a nested call chain, the deepest counted level, levels past the limit
        set_config(1'b1, 6'd62);
        queue_record(10'd3, 8'd2, 63'd120, 63'd130, 63'd120, 63'd125,
            48'd10, 48'd20, 48'd30, 48'd40);
        queue_record(10'd2, 8'd1, 63'd110, 63'd150, 63'd110, 63'd140,
            48'd10, 48'd5, 48'd30, 48'd45);
        queue_record(10'd4, 8'd1, 63'd155, 63'd160, 63'd145, 63'd148,
            48'd5, 48'd6, 48'd45, 48'd46);
        queue_record(10'd1, 8'd0, 63'd100, 63'd200, 63'd100, 63'd180,
            48'd0, 48'd6, 48'd0, 48'd46);
        queue_record(10'd5, 8'd62, 63'd1000, 63'd1500, 63'd1000, 63'd1200,
            48'd7, 48'd7, 48'd7, 48'd7);
        queue_record(10'd6, 8'd61, 63'd900, 63'd1600, 63'd900, 63'd1300,
            48'd7, 48'd8, 48'd7, 48'd8);
        queue_record(10'd7, 8'd63, 63'd1, 63'd2, 63'd1, 63'd2, 48'd1, 48'd2, 48'd1, 48'd3);
        queue_record(10'd8, 8'd64, 63'd1, 63'd9, 63'd1, 63'd9, 48'd9, 48'd1, 48'd1, 48'd9);
        queue_record(10'd8, 8'd255, TIME_MAX, '0, '0, TIME_MAX, '0, MEM_MAX, MEM_MAX, '0);
        queue_record(10'd1, 8'd0, 63'd500, 63'd400, 63'd500, 63'd450,
            48'd50, 48'd40, 48'd60, 48'd55);
        wait_idle();

        // Only level zero is counted
        set_config(1'b1, 6'd0);
        queue_record(10'd9, 8'd1, 63'd10, 63'd20, 63'd10, 63'd15, 48'd0, 48'd4, 48'd0, 48'd4);
        queue_record(10'd9, 8'd0, 63'd5, 63'd30, 63'd5, 63'd20, 48'd0, 48'd8, 48'd0, 48'd9);
        queue_record(10'd10, 8'd0, 63'd40, 63'd41, 63'd40, 63'd41, 48'd8, 48'd8, 48'd9, 48'd9);
        wait_idle();

        // Random traffic across several settings; the first phase includes the long hold-off
        set_config(1'b1, 6'd62);
        queue_random_records(RANDOM_PER_PHASE);
        hold_request = 1'b1;
        wait_idle();

        set_config(1'b0, 6'd33);
        queue_random_records(RANDOM_PER_PHASE);
        wait_idle();

        set_config(1'b1, 6'd0);
        queue_random_records(RANDOM_PER_PHASE);
        wait_idle();

        set_config(1'b1, 6'($urandom_range(1, 61)));
        queue_random_records(RANDOM_PER_PHASE);
        wait_idle();

        set_config(1'b0, 6'd62);
        queue_random_records(RANDOM_PER_PHASE);
        wait_idle();

        // Last stretch runs back to back with no idling on either side
        set_config(1'b1, 6'd62);
        calm = 1'b1;
        queue_random_records(RANDOM_PER_PHASE);

        guard = 0;
        while (records_outstanding != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (records_outstanding != 0 || expected_totals.size() != 0) begin
            report_mismatch($sformatf("%0d records never produced a result",
                records_outstanding));
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cpa_pkg.sv
rtl/cpa_func_table.sv
rtl/cpa_level_table.sv
rtl/cpa_engine.sv
rtl/call_profile_accumulator.sv
sim/call_profile_accumulator_test.sv
